### design/assert_macros.svh
// assertion macros for the scan rate detector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition never true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### design/tsrd_pkg.sv
// package: types, constants and classifier for the scan rate detector
package tsrd_pkg;

   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [5:0]  FLAGS_SYN_ONLY = 6'h02;
   localparam logic [5:0]  FLAGS_NONE     = 6'h00;
   localparam logic [5:0]  FLAGS_FIN_ONLY = 6'h01;
   localparam logic [5:0]  FLAGS_XMAS     = 6'h29;
   localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

   localparam int NUM_KINDS = 4;

   localparam logic [1:0] KIND_SYN  = 2'd0;
   localparam logic [1:0] KIND_NULL = 2'd1;
   localparam logic [1:0] KIND_FIN  = 2'd2;
   localparam logic [1:0] KIND_XMAS = 2'd3;

   localparam logic [1:0] CSR_SYN_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_NULL_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_FIN_THRESHOLD  = 2'd2;
   localparam logic [1:0] CSR_XMAS_THRESHOLD = 2'd3;

   localparam logic [15:0] RESET_SYN_THRESHOLD   = 16'd256;
   localparam logic [15:0] RESET_OTHER_THRESHOLD = 16'd8;

   typedef struct packed {
      logic [7:0]  protocol;
      logic [31:0] source_address;
      logic [5:0]  tcp_flags;
      logic [31:0] now_seconds;
   } req_item_type;

   typedef struct packed {
      logic        alert;
      logic [1:0]  scan_kind;
      logic [31:0] alert_source;
      logic [31:0] alert_count;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] last_source;
      logic [31:0] last_second;
      logic [31:0] packet_count;
      logic [15:0] count_phase;
   } entry_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
   } class_type;

   typedef struct packed {
      logic         write_en;
      entry_type    entry;
      rsp_item_type result;
   } update_type;

   function automatic class_type classify(input logic [7:0] protocol,
                                          input logic [5:0] flags);
      class_type c;
      c.valid = 1'b0;
      c.kind  = KIND_SYN;
      if (protocol == PROTO_TCP) begin
         priority if (flags == FLAGS_SYN_ONLY) begin
            c.valid = 1'b1;
            c.kind  = KIND_SYN;
         end else if (flags == FLAGS_NONE) begin
            c.valid = 1'b1;
            c.kind  = KIND_NULL;
         end else if (flags == FLAGS_FIN_ONLY) begin
            c.valid = 1'b1;
            c.kind  = KIND_FIN;
         end else if (flags == FLAGS_XMAS) begin
            c.valid = 1'b1;
            c.kind  = KIND_XMAS;
         end else begin
            c.valid = 1'b0;
         end
      end
      return c;
   endfunction

endpackage

### design/tsrd_if.sv
// valid/ready channel interfaces for packet headers and scan results
interface tsrd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  protocol;
   logic [31:0] source_address;
   logic [5:0]  tcp_flags;
   logic [31:0] now_seconds;

   modport source (output valid, output protocol, output source_address,
                   output tcp_flags, output now_seconds, input ready);
   modport sink   (input valid, input protocol, input source_address,
                   input tcp_flags, input now_seconds, output ready);
endinterface

interface tsrd_rsp_if;
   logic        valid;
   logic        ready;
   logic        alert;
   logic [1:0]  scan_kind;
   logic [31:0] alert_source;
   logic [31:0] alert_count;

   modport source (output valid, output alert, output scan_kind,
                   output alert_source, output alert_count, input ready);
   modport sink   (input valid, input alert, input scan_kind,
                   input alert_source, input alert_count, output ready);
endinterface

### design/tsrd_update.sv
// per-class entry update: repeat match, counter, phase and alert
module tsrd_update (
   input  tsrd_pkg::req_item_type item,
   input  tsrd_pkg::class_type    cls,
   input  tsrd_pkg::entry_type    entry,
   input  logic [15:0]            threshold,
   output tsrd_pkg::update_type   upd
);
   import tsrd_pkg::*;

   logic        match;
   logic [16:0] next_phase;

   assign match      = (entry.last_source == item.source_address) &&
                       (entry.last_second == item.now_seconds);
   assign next_phase = {1'b0, entry.count_phase} + 17'd1;

   always_comb begin
      upd.write_en = cls.valid;
      upd.entry    = entry;
      upd.result   = '0;
      if (match) begin
         if (entry.packet_count != COUNT_MAX) begin
            upd.entry.packet_count = entry.packet_count + 32'd1;
            if (next_phase >= {1'b0, threshold}) begin
               upd.result.alert       = 1'b1;
               upd.entry.count_phase  = '0;
            end else begin
               upd.entry.count_phase  = next_phase[15:0];
            end
         end
      end else begin
         upd.entry.last_source  = item.source_address;
         upd.entry.last_second  = item.now_seconds;
         upd.entry.packet_count = '0;
         upd.entry.count_phase  = '0;
      end
      upd.result.scan_kind    = cls.kind;
      upd.result.alert_source = upd.entry.last_source;
      upd.result.alert_count  = upd.entry.packet_count;
      // ignored packet gives an all-zero result
      if (!cls.valid) begin
         upd.result = '0;
      end
   end

endmodule

### design/tcp_scan_rate_detector.sv
// top level: per-second tcp scan rate detector
// an accepted header is held in the input register; its result is registered in the output register when it advances
// throughput: one header per cycle while the output is not stalled, state read and written in one result stage
// input register takes one more header while a result waits in the output register
// reset clears thresholds to defaults, all class entries to zero, both stages empty
`include "assert_macros.svh"

module tcp_scan_rate_detector (
   input  logic        clock,
   input  logic        reset,
   tsrd_req_if.sink    req_chan,
   tsrd_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tsrd_pkg::*;

   logic [15:0]  threshold_ff [NUM_KINDS];
   entry_type    entry_ff     [NUM_KINDS];

   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   req_item_type req_item;
   class_type    cls;
   update_type   upd;
   logic         advance;
   logic         req_take;

   assign req_item.protocol       = req_chan.protocol;
   assign req_item.source_address = req_chan.source_address;
   assign req_item.tcp_flags      = req_chan.tcp_flags;
   assign req_item.now_seconds    = req_chan.now_seconds;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign cls = classify(s1_item_ff.protocol, s1_item_ff.tcp_flags);

   tsrd_update u_update (
      .item      (s1_item_ff),
      .cls       (cls),
      .entry     (entry_ff[cls.kind]),
      .threshold (threshold_ff[cls.kind]),
      .upd       (upd)
   );

   // thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff[KIND_SYN]  <= RESET_SYN_THRESHOLD;
         threshold_ff[KIND_NULL] <= RESET_OTHER_THRESHOLD;
         threshold_ff[KIND_FIN]  <= RESET_OTHER_THRESHOLD;
         threshold_ff[KIND_XMAS] <= RESET_OTHER_THRESHOLD;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYN_THRESHOLD:  threshold_ff[KIND_SYN]  <= csr_wdata;
            CSR_NULL_THRESHOLD: threshold_ff[KIND_NULL] <= csr_wdata;
            CSR_FIN_THRESHOLD:  threshold_ff[KIND_FIN]  <= csr_wdata;
            CSR_XMAS_THRESHOLD: threshold_ff[KIND_XMAS] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // class entries
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KINDS; k++) begin
            entry_ff[k] <= '0;
         end
      end else if (advance && upd.write_en) begin
         entry_ff[cls.kind] <= upd.entry;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= upd.result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.alert        = rsp_item_ff.alert;
   assign rsp_chan.scan_kind    = rsp_item_ff.scan_kind;
   assign rsp_chan.alert_source = rsp_item_ff.alert_source;
   assign rsp_chan.alert_count  = rsp_item_ff.alert_count;

   `ASSERT_CLK(a_alert_count_nonzero, clock, reset,
      rsp_valid_ff && rsp_item_ff.alert |-> rsp_item_ff.alert_count != 32'd0,
      "alert with zero count")
   `ASSERT_CLK(a_s1_holds_when_stalled, clock, reset,
      s1_valid_ff && !advance |=> s1_valid_ff,
      "input stage item lost while stalled")
   `ASSERT_NEVER(a_no_overwrite, clock, reset,
      req_take && s1_valid_ff && !advance,
      "input stage overwritten")

endmodule
